[rtl/assert_macros.svh]
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clock edge outside reset
`define FBRG_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fbrg assertion failed");

// same check with a message of the caller's choice
`define FBRG_ASSERT_MSG(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

[rtl/fbrg_pkg.sv]
// shared types, codes, font and color helpers for the framebuffer drawer
package fbrg_pkg;

  // command codes of the func field
  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_FILL  = 2'd1;
  localparam logic [1:0] FUNC_DIGIT = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  // ascii range that draws a glyph
  localparam logic [7:0] CHAR_ZERO = 8'd48;
  localparam logic [7:0] CHAR_NINE = 8'd57;

  // signed width for box arithmetic, holds coordinates and panel widths up to 2047
  localparam int SW = 12;

  // glyph dot grid
  localparam logic [2:0] DOT_ROW_LAST = 3'd4;
  localparam logic [1:0] DOT_COL_LAST = 2'd2;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic box_load;
    logic draw_step;
    logic dot_next;
    logic out_load;
  } fbrg_cmd_t;

  typedef struct packed {
    logic is_digit;
    logic glyph_ok;
    logic dot_set;
    logic dot_last;
    logic box_empty;
    logic box_last;
    logic clr_last;
    logic out_free;
  } fbrg_sts_t;

  // 3x5 digit font, msb is the left column
  function automatic logic [2:0] font_row(input logic [3:0] digit, input logic [2:0] row);
    logic [14:0] g;
    begin
      case (digit)
        4'd0:    g = {3'h7, 3'h5, 3'h5, 3'h5, 3'h7};
        4'd1:    g = {3'h2, 3'h6, 3'h2, 3'h2, 3'h7};
        4'd2:    g = {3'h7, 3'h1, 3'h7, 3'h4, 3'h7};
        4'd3:    g = {3'h7, 3'h1, 3'h7, 3'h1, 3'h7};
        4'd4:    g = {3'h5, 3'h5, 3'h7, 3'h1, 3'h1};
        4'd5:    g = {3'h7, 3'h4, 3'h7, 3'h1, 3'h7};
        4'd6:    g = {3'h7, 3'h4, 3'h7, 3'h5, 3'h7};
        4'd7:    g = {3'h7, 3'h1, 3'h1, 3'h1, 3'h1};
        4'd8:    g = {3'h7, 3'h5, 3'h7, 3'h5, 3'h7};
        4'd9:    g = {3'h7, 3'h5, 3'h7, 3'h1, 3'h7};
        default: g = 15'd0;
      endcase
      case (row)
        3'd0:    font_row = g[14:12];
        3'd1:    font_row = g[11:9];
        3'd2:    font_row = g[8:6];
        3'd3:    font_row = g[5:3];
        3'd4:    font_row = g[2:0];
        default: font_row = 3'd0;
      endcase
    end
  endfunction

  function automatic logic [7:0] expand5(input logic [4:0] v);
    expand5 = {v, v[4:2]};
  endfunction

  function automatic logic [7:0] expand6(input logic [5:0] v);
    expand6 = {v, v[5:4]};
  endfunction

endpackage

[rtl/fbrg_ctrl.sv]
// command sequencer of the framebuffer drawer
module fbrg_ctrl import fbrg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] func_i,
  input  fbrg_sts_t  sts_i,
  output logic       in_stall_o,
  output fbrg_cmd_t  cmd_o
);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CLR   = 3'd2;
  localparam logic [2:0] S_DOT   = 3'd3;
  localparam logic [2:0] S_SETUP = 3'd4;
  localparam logic [2:0] S_DRAW  = 3'd5;
  localparam logic [2:0] S_READ  = 3'd6;
  localparam logic [2:0] S_RESP  = 3'd7;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_INIT: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          case (func_i)
            FUNC_CLEAR: state_d = S_CLR;
            FUNC_FILL:  state_d = S_SETUP;
            FUNC_DIGIT: state_d = S_DOT;
            FUNC_READ:  state_d = S_READ;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_DOT: begin
        if (!sts_i.glyph_ok) begin
          state_d = S_IDLE;
        end else if (sts_i.dot_set) begin
          state_d = S_SETUP;
        end else if (sts_i.dot_last) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.dot_next = 1'b1;
        end
      end
      S_SETUP: begin
        cmd_o.box_load = 1'b1;
        state_d        = S_DRAW;
      end
      S_DRAW: begin
        cmd_o.draw_step = !sts_i.box_empty;
        if (sts_i.box_empty || sts_i.box_last) begin
          // a glyph goes back for its next dot
          if (sts_i.is_digit && !sts_i.dot_last) begin
            cmd_o.dot_next = 1'b1;
            state_d        = S_DOT;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_READ: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

endmodule

[rtl/fbrg_dp.sv]
// framebuffer memory, clear sweep, glyph dot walk, box clipping, pixel walk and read result register
module fbrg_dp import fbrg_pkg::*; #(
  parameter int PANEL_WIDTH  = 64,
  parameter int PANEL_HEIGHT = 32,
  parameter int CHAIN_COUNT  = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fbrg_cmd_t         cmd_i,
  output fbrg_sts_t         sts_o,
  input  logic [1:0]        func_i,
  input  logic signed [8:0] x_pos_i,
  input  logic signed [8:0] y_pos_i,
  input  logic [7:0]        rect_width_i,
  input  logic [7:0]        rect_height_i,
  input  logic [7:0]        char_code_i,
  input  logic [3:0]        scale_i,
  input  logic [15:0]       color_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [15:0]       pixel_value_o,
  output logic [7:0]        red_o,
  output logic [7:0]        green_o,
  output logic [7:0]        blue_o,
  output logic              outside_o
);

  localparam int TOTAL_W = PANEL_WIDTH * CHAIN_COUNT;
  localparam int DEPTH   = TOTAL_W * PANEL_HEIGHT;
  localparam int AW      = $clog2(DEPTH);
  localparam int CW      = $clog2(TOTAL_W + 1);
  localparam int RW      = $clog2(PANEL_HEIGHT + 1);
  localparam logic signed [SW-1:0] TW_S = SW'(TOTAL_W);
  localparam logic signed [SW-1:0] PH_S = SW'(PANEL_HEIGHT);
  localparam logic [AW-1:0] TW_A   = AW'(TOTAL_W);
  localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

  logic [15:0] mem [DEPTH];
  logic [15:0] rd_q;

  // latched command
  logic              is_digit_q;
  logic              glyph_ok_q;
  logic [3:0]        dig_q;
  logic signed [8:0] x_q, y_q;
  logic [7:0]        w_q, h_q;
  logic [3:0]        s_q;
  logic [15:0]       color_q;

  // glyph dot walk
  logic [2:0] drow_q;
  logic [1:0] dcol_q;

  // clipped box and pixel walk
  logic          empty_q;
  logic [CW-1:0] x0_q, x1_q, col_q;
  logic [RW-1:0] y1_q, row_q;
  logic [AW-1:0] row_base_q;
  logic [AW-1:0] clr_q;

  logic out_valid_q;
  logic outside_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q     <= x_pos_i;
      y_q     <= y_pos_i;
      w_q     <= rect_width_i;
      h_q     <= rect_height_i;
      s_q     <= scale_i;
      color_q <= color_i;
      dig_q   <= 4'(char_code_i - CHAR_ZERO);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_digit_q <= 1'b0;
      glyph_ok_q <= 1'b0;
    end else if (cmd_i.load) begin
      is_digit_q <= (func_i == FUNC_DIGIT);
      glyph_ok_q <= (char_code_i >= CHAR_ZERO) && (char_code_i <= CHAR_NINE) &&
                    (scale_i != 4'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drow_q <= '0;
      dcol_q <= '0;
    end else if (cmd_i.load) begin
      drow_q <= '0;
      dcol_q <= '0;
    end else if (cmd_i.dot_next) begin
      if (dcol_q == DOT_COL_LAST) begin
        dcol_q <= '0;
        drow_q <= drow_q + 3'd1;
      end else begin
        dcol_q <= dcol_q + 2'd1;
      end
    end
  end

  logic [2:0] row_bits;
  assign row_bits = font_row(dig_q, drow_q);

  // box of the current dot or of the rectangle, clipped to the panel
  logic [5:0]           offx_u;
  logic [6:0]           offy_u;
  logic signed [SW-1:0] xs, ys, bx, by, bw, bh, x1r, y1r, x0c, y0c, x1c, y1c;

  always_comb begin
    offx_u = 6'(dcol_q) * 6'(s_q);
    offy_u = 7'(drow_q) * 7'(s_q);
    xs     = SW'(x_q);
    ys     = SW'(y_q);
    if (is_digit_q) begin
      bx = xs + $signed(SW'(offx_u));
      by = ys + $signed(SW'(offy_u));
      bw = $signed(SW'(s_q));
      bh = $signed(SW'(s_q));
    end else begin
      bx = xs;
      by = ys;
      bw = $signed(SW'(w_q));
      bh = $signed(SW'(h_q));
    end
    x1r = bx + bw;
    y1r = by + bh;
    x0c = (bx < 0) ? '0 : bx;
    y0c = (by < 0) ? '0 : by;
    x1c = (x1r > TW_S) ? TW_S : x1r;
    y1c = (y1r > PH_S) ? PH_S : y1r;
  end

  logic [CW-1:0] col_nx;
  logic [RW-1:0] row_nx;
  logic          col_end, row_end;
  assign col_nx  = col_q + CW'(1);
  assign row_nx  = row_q + RW'(1);
  assign col_end = (col_nx == x1_q);
  assign row_end = (row_nx == y1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_q <= 1'b1;
    end else if (cmd_i.box_load) begin
      empty_q <= (x1c <= x0c) || (y1c <= y0c);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.box_load) begin
      x0_q       <= CW'(x0c);
      x1_q       <= CW'(x1c);
      y1_q       <= RW'(y1c);
      col_q      <= CW'(x0c);
      row_q      <= RW'(y0c);
      row_base_q <= AW'(RW'(y0c)) * TW_A;
    end else if (cmd_i.draw_step) begin
      if (col_end) begin
        col_q      <= x0_q;
        row_q      <= row_nx;
        row_base_q <= row_base_q + TW_A;
      end else begin
        col_q <= col_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.load) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  // memory ports
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wdata;
  logic          in_panel;

  assign we       = cmd_i.clr_step || cmd_i.draw_step;
  assign waddr    = cmd_i.clr_step ? clr_q : (row_base_q + AW'(col_q));
  assign wdata    = cmd_i.clr_step ? 16'd0 : color_q;
  assign in_panel = (xs >= 0) && (xs < TW_S) && (ys >= 0) && (ys < PH_S);
  assign raddr    = AW'(y_q[7:0]) * TW_A + AW'(x_q[7:0]);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      outside_q     <= !in_panel;
      pixel_value_o <= in_panel ? rd_q : 16'd0;
      red_o         <= in_panel ? expand5(rd_q[15:11]) : 8'd0;
      green_o       <= in_panel ? expand6(rd_q[10:5]) : 8'd0;
      blue_o        <= in_panel ? expand5(rd_q[4:0]) : 8'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign outside_o   = outside_q;

  always_comb begin
    sts_o           = '0;
    sts_o.is_digit  = is_digit_q;
    sts_o.glyph_ok  = glyph_ok_q;
    sts_o.dot_set   = row_bits[2'd2 - dcol_q];
    sts_o.dot_last  = (drow_q == DOT_ROW_LAST) && (dcol_q == DOT_COL_LAST);
    sts_o.box_empty = empty_q;
    sts_o.box_last  = col_end && row_end;
    sts_o.clr_last  = (clr_q == CLR_LAST);
    sts_o.out_free  = !out_valid_q || !out_stall_i;
  end

endmodule

[rtl/framebuffer_rect_and_glyph_drawer.sv]
// top level of the rgb565 framebuffer rectangle and digit drawer
// The block holds a PANEL_WIDTH*CHAIN_COUNT by PANEL_HEIGHT rgb565 picture in one
// single-port-write, registered-read memory and takes one command item at a time;
// in_stall_o stays high until the item is finished. After reset a clearing pass
// writes zero to every pixel, one per cycle, before the first item is taken.
// Pixel writes go through the single memory write port at one per cycle: clear
// sweeps every pixel; fill loads its clipped rectangle and writes its pixels, none
// when nothing is left after clipping; a digit visits the glyph dots in order (all
// 15 for a drawable digit, 1 for a non-digit code or zero scale) and each set dot
// loads and writes its clipped square; a read latches its position, registers the
// memory word and then loads the result register once that is free. The result
// sits in an output register so that the next item may start while it waits to
// be taken.
`include "assert_macros.svh"

module framebuffer_rect_and_glyph_drawer import fbrg_pkg::*; #(
  parameter int PANEL_WIDTH  = 64,
  parameter int PANEL_HEIGHT = 32,
  parameter int CHAIN_COUNT  = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        func_i,
  input  logic signed [8:0] x_pos_i,
  input  logic signed [8:0] y_pos_i,
  input  logic [7:0]        rect_width_i,
  input  logic [7:0]        rect_height_i,
  input  logic [7:0]        char_code_i,
  input  logic [3:0]        scale_i,
  input  logic [15:0]       color_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [15:0]       pixel_value_o,
  output logic [7:0]        red_o,
  output logic [7:0]        green_o,
  output logic [7:0]        blue_o,
  output logic              outside_o
);

  fbrg_cmd_t cmd;
  fbrg_sts_t sts;

  fbrg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  fbrg_dp #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT),
    .CHAIN_COUNT  (CHAIN_COUNT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .func_i        (func_i),
    .x_pos_i       (x_pos_i),
    .y_pos_i       (y_pos_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .char_code_i   (char_code_i),
    .scale_i       (scale_i),
    .color_i       (color_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .pixel_value_o (pixel_value_o),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .outside_o     (outside_o)
  );

  // an accepted item always keeps the block busy in the cycle after it is taken
  `FBRG_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o)
  // never overwrite a result that has not been taken
  `FBRG_ASSERT_MSG(a_no_result_overrun, clk_i, rst_ni, cmd.out_load |-> sts.out_free, "result overrun")
  // pixel writes only inside a non-empty clipped box
  `FBRG_ASSERT(a_draw_in_box, clk_i, rst_ni, cmd.draw_step |-> !sts.box_empty)
  // memory sweep, box setup, pixel walk and item load never overlap
  `FBRG_ASSERT(a_cmd_exclusive, clk_i, rst_ni, $onehot0({cmd.load, cmd.clr_step, cmd.box_load, cmd.draw_step}))

endmodule

[test/tb_top.sv]
// testbench for the framebuffer rectangle and digit drawer, with a predicting scoreboard
import fbrg_pkg::*;

localparam int PANEL_COLS = 64 * 1;
localparam int PANEL_ROWS = 32;
localparam int PIXEL_COUNT = PANEL_COLS * PANEL_ROWS;

typedef struct {
  logic [15:0] pixel_value;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        outside;
} pixel_read_t;

class frame_predictor;
  logic [15:0] picture [PIXEL_COUNT];
  pixel_read_t reads_due [$];
  int unsigned mismatches;

  function new();
    foreach (picture[i]) picture[i] = 16'h0000;
    mismatches = 0;
  endfunction

  // 3x5 dots, top row in the high bits, left column first
  function logic [14:0] glyph(int d);
    case (d)
      0:       return 15'b111_101_101_101_111;
      1:       return 15'b010_110_010_010_111;
      2:       return 15'b111_001_111_100_111;
      3:       return 15'b111_001_111_001_111;
      4:       return 15'b101_101_111_001_001;
      5:       return 15'b111_100_111_001_111;
      6:       return 15'b111_100_111_101_111;
      7:       return 15'b111_001_001_001_001;
      8:       return 15'b111_101_111_101_111;
      9:       return 15'b111_101_111_001_111;
      default: return 15'b0;
    endcase
  endfunction

  function void paint(int x, int y, int w, int h, logic [15:0] c);
    int x0, y0, x1, y1;
    x0 = (x < 0) ? 0 : x;
    y0 = (y < 0) ? 0 : y;
    x1 = (x + w > PANEL_COLS) ? PANEL_COLS : x + w;
    y1 = (y + h > PANEL_ROWS) ? PANEL_ROWS : y + h;
    for (int j = y0; j < y1; j++)
      for (int i = x0; i < x1; i++)
        picture[j * PANEL_COLS + i] = c;
  endfunction

  function void note_command(logic [1:0] f, logic signed [8:0] xp, logic signed [8:0] yp,
                             logic [7:0] w, logic [7:0] h, logic [7:0] ch,
                             logic [3:0] sc, logic [15:0] c);
    int xi, yi, s;
    logic [14:0] dots;
    logic [15:0] p;
    logic [7:0] r, g, b;
    pixel_read_t rd;
    xi = int'(xp);
    yi = int'(yp);
    s = int'(sc);
    case (f)
      FUNC_CLEAR: foreach (picture[i]) picture[i] = 16'h0000;
      FUNC_FILL:  paint(xi, yi, int'(w), int'(h), c);
      FUNC_DIGIT: begin
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE && s != 0) begin
          dots = glyph(int'(ch - CHAR_ZERO));
          for (int row = 0; row < 5; row++)
            for (int col = 0; col < 3; col++)
              if (dots[14 - 3 * row - col])
                paint(xi + col * s, yi + row * s, s, s, c);
        end
      end
      FUNC_READ: begin
        if (xi < 0 || xi >= PANEL_COLS || yi < 0 || yi >= PANEL_ROWS) begin
          rd = '{16'h0000, 8'h00, 8'h00, 8'h00, 1'b1};
        end else begin
          p = picture[yi * PANEL_COLS + xi];
          r = 8'(p[15:11]);
          g = 8'(p[10:5]);
          b = 8'(p[4:0]);
          rd = '{p, (r << 3) | (r >> 2), (g << 2) | (g >> 4), (b << 3) | (b >> 2), 1'b0};
        end
        reads_due.push_back(rd);
      end
      default: ;
    endcase
  endfunction

  function void compare(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function void check_read(logic [15:0] pv, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                           logic outs);
    pixel_read_t want;
    if (reads_due.size() == 0) begin
      $display("%0t: unexpected read result expected none got pixel %0h outside %0b",
               $time, pv, outs);
      mismatches++;
    end else begin
      want = reads_due.pop_front();
      compare("pixel_value", want.pixel_value, pv);
      compare("red", 16'(want.red), 16'(r));
      compare("green", 16'(want.green), 16'(g));
      compare("blue", 16'(want.blue), 16'(b));
      compare("outside", 16'(want.outside), 16'(outs));
    end
  endfunction

  function int pending();
    return reads_due.size();
  endfunction
endclass

module tb_top;
  localparam int unsigned CYCLE_LIMIT = 20_000_000;
  localparam int RANDOM_ITEMS = 1950;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        func_i;
  logic signed [8:0] x_pos_i;
  logic signed [8:0] y_pos_i;
  logic [7:0]        rect_width_i;
  logic [7:0]        rect_height_i;
  logic [7:0]        char_code_i;
  logic [3:0]        scale_i;
  logic [15:0]       color_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [15:0]       pixel_value_o;
  logic [7:0]        red_o;
  logic [7:0]        green_o;
  logic [7:0]        blue_o;
  logic              outside_o;

  frame_predictor frame_pred = new();
  bit quiet = 1'b0;
  int unsigned cycle_count = 0;

  framebuffer_rect_and_glyph_drawer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .x_pos_i       (x_pos_i),
    .y_pos_i       (y_pos_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .char_code_i   (char_code_i),
    .scale_i       (scale_i),
    .color_i       (color_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_value_o (pixel_value_o),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .outside_o     (outside_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: values read here are the ones from before the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        frame_pred.check_read(pixel_value_o, red_o, green_o, blue_o, outside_o);
      out_stall_i <= quiet ? 1'b0 : ($urandom_range(0, 99) < 37);
    end
  end

  task automatic send_item(logic [1:0] f, logic signed [8:0] x, logic signed [8:0] y,
                           logic [7:0] w, logic [7:0] h, logic [7:0] ch,
                           logic [3:0] s, logic [15:0] c);
    while (!quiet && $urandom_range(0, 99) < 37) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= f;
    x_pos_i       <= x;
    y_pos_i       <= y;
    rect_width_i  <= w;
    rect_height_i <= h;
    char_code_i   <= ch;
    scale_i       <= s;
    color_i       <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    frame_pred.note_command(f, x, y, w, h, ch, s, c);
  endtask

  // hold the sender back until every read has been answered
  task automatic wait_reads_done();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (frame_pred.pending() != 0) @(posedge clk_i);
  endtask

  task automatic send_random_item();
    logic [1:0] f;
    logic signed [8:0] x, y;
    logic [7:0] w, h, ch;
    logic [3:0] s;
    logic [15:0] c;
    int pick;
    pick = $urandom_range(0, 99);
    f = (pick < 2) ? FUNC_CLEAR : (pick < 42) ? FUNC_READ : (pick < 70) ? FUNC_FILL : FUNC_DIGIT;
    x = 9'($urandom);
    y = 9'($urandom);
    w = 8'($urandom);
    h = 8'($urandom);
    ch = 8'($urandom);
    s = 4'($urandom);
    c = 16'($urandom);
    // mostly small figures near the panel, now and then the full ranges
    if ($urandom_range(0, 19) != 0) begin
      x = 9'($urandom_range(0, 79) - 12);
      y = 9'($urandom_range(0, 47) - 12);
      w = 8'($urandom_range(0, 16));
      h = 8'($urandom_range(0, 16));
      s = 4'($urandom_range(0, 4));
    end
    if ($urandom_range(0, 6) != 0) ch = 8'(CHAR_ZERO + $urandom_range(0, 9));
    send_item(f, x, y, w, h, ch, s, c);
  endtask

  initial begin
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    out_stall_i   <= 1'b0;
    func_i        <= FUNC_CLEAR;
    x_pos_i       <= '0;
    y_pos_i       <= '0;
    rect_width_i  <= '0;
    rect_height_i <= '0;
    char_code_i   <= '0;
    scale_i       <= '0;
    color_i       <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // corners and off-panel reads of the cleared picture
    send_item(FUNC_READ, 0, 0, 0, 0, 0, 0, 0);
    send_item(FUNC_READ, 63, 31, 0, 0, 0, 0, 0);
    send_item(FUNC_READ, -256, 0, 0, 0, 0, 0, 0);
    send_item(FUNC_READ, 255, 255, 0, 0, 0, 0, 0);
    send_item(FUNC_READ, 64, 0, 0, 0, 0, 0, 0);
    send_item(FUNC_READ, 0, 32, 0, 0, 0, 0, 0);
    // rectangle ending just before the panel, then one covering all of it
    send_item(FUNC_FILL, -256, -256, 255, 255, 0, 0, 16'hFFFF);
    send_item(FUNC_FILL, -5, -5, 255, 255, 0, 0, 16'hF81F);
    send_item(FUNC_READ, 63, 31, 0, 0, 0, 0, 0);
    // empty rectangles, one clipped at the panel corner, and a digit at the origin
    send_item(FUNC_FILL, 10, 10, 0, 5, 0, 0, 16'h1234);
    send_item(FUNC_FILL, 10, 10, 5, 0, 0, 0, 16'h1234);
    send_item(FUNC_FILL, 60, 28, 8, 8, 0, 0, 16'h07E0);
    send_item(FUNC_READ, 63, 31, 0, 0, 0, 0, 0);
    send_item(FUNC_READ, 10, 10, 0, 0, 0, 0, 0);
    send_item(FUNC_DIGIT, 0, 0, 0, 0, CHAR_ZERO + 8'd8, 1, 16'hFFFF);
    send_item(FUNC_READ, 1, 1, 0, 0, 0, 0, 0);
    send_item(FUNC_READ, 0, 1, 0, 0, 0, 0, 0);
    // codes just around the digits and a zero scale draw nothing; then a large clipped digit and a clear
    send_item(FUNC_DIGIT, 20, 5, 0, 0, CHAR_ZERO - 8'd1, 3, 16'h0000);
    send_item(FUNC_DIGIT, 20, 5, 0, 0, CHAR_NINE + 8'd1, 3, 16'h0000);
    send_item(FUNC_DIGIT, 20, 5, 0, 0, 8'hFF, 3, 16'h0000);
    send_item(FUNC_DIGIT, 20, 5, 0, 0, CHAR_ZERO, 0, 16'h0000);
    send_item(FUNC_DIGIT, -10, -20, 0, 0, CHAR_NINE - 8'd2, 15, 16'h001F);
    send_item(FUNC_READ, 20, 5, 0, 0, 0, 0, 0);
    send_item(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    send_item(FUNC_READ, 5, 5, 0, 0, 0, 0, 0);
    wait_reads_done();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= 800 && n < 1100);
      if (n == 1300) wait_reads_done();
      send_random_item();
    end
    quiet = 1'b0;

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (frame_pred.pending() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (frame_pred.mismatches == 0 && frame_pred.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

[framebuffer_rect_and_glyph_drawer.f]
+incdir+rtl
rtl/fbrg_pkg.sv
rtl/fbrg_ctrl.sv
rtl/fbrg_dp.sv
rtl/framebuffer_rect_and_glyph_drawer.sv
test/tb_top.sv
